[rtl/wcep_pkg.sv]
// Package with the types, codes and constants of the constant expression parser.
package wcep_pkg;

  localparam logic [7:0] OP_I32_CONST  = 8'h41;
  localparam logic [7:0] OP_I64_CONST  = 8'h42;
  localparam logic [7:0] OP_F32_CONST  = 8'h43;
  localparam logic [7:0] OP_F64_CONST  = 8'h44;
  localparam logic [7:0] OP_GLOBAL_GET = 8'h23;
  localparam logic [7:0] OP_END        = 8'h0b;

  localparam logic [7:0] LEB_PAYLOAD = 8'h7f;
  localparam logic [7:0] LEB_MORE    = 8'h80;

  localparam logic [6:0] BITPOS_STEP = 7'd7;
  localparam logic [6:0] BITPOS_SAT  = 7'd70;

  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_EOS  = 2'd1;

  typedef enum logic [2:0] {
    KIND_I32    = 3'd0,
    KIND_I64    = 3'd1,
    KIND_F32    = 3'd2,
    KIND_F64    = 3'd3,
    KIND_GLOBAL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_LEB_EOS = 2'd2,
    ST_LEB_ERR = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_OPCODE = 4'b0001,
    PH_LEB    = 4'b0010,
    PH_RAW    = 4'b0100,
    PH_END    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]  expr_kind;
    logic [63:0] expr_value;
    logic [1:0]  status;
  } result_t;

endpackage

[rtl/wcep_in_if.sv]
// Interface of the input byte/event channel.
interface wcep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic [1:0] event_req;

  modport source (output valid, output in_byte, output event_req, input ready);
  modport sink   (input valid, input in_byte, input event_req, output ready);
endinterface

[rtl/wcep_out_if.sv]
// Interface of the result channel.
interface wcep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  expr_kind;
  logic [63:0] expr_value;
  logic [1:0]  status;

  modport source (output valid, output expr_kind, output expr_value, output status,
                  input ready);
  modport sink   (input valid, input expr_kind, input expr_value, input status,
                  output ready);
endinterface

[rtl/wasm_const_expr_parser.sv]
// Top level of the WebAssembly constant initializer expression parser.
// The block takes one stream byte or stream event per request on in_ch and parses
// constant expressions (opcode, LEB128 or raw float operand, end byte) back to back,
// giving one result per expression on out_ch: the kind, the zero-extended operand
// and a status. Every request passes an input register and the parser logic
// (a 64-bit shift-and-OR into the accumulator); a result lands in a result
// register. The block takes one request per cycle while the pipe does not stall,
// and a result is offered on out_ch once the end byte or the failing byte has
// passed the input register and the parser logic. The input register refills
// while a result waits on out_ch; the pipe stalls only when the result register
// is full and not being taken. End-of-stream or read-error events between
// expressions are consumed silently; any non-ok status reports a value of zero.
module wasm_const_expr_parser (
  input logic        clk,
  input logic        rst_n,
  wcep_in_if.sink    in_ch,
  wcep_out_if.source out_ch
);
  import wcep_pkg::*;

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic [1:0] in_event_r;

  // Result register.
  logic    out_valid_r;
  result_t out_res_r;

  logic    advance;
  logic    emit;
  result_t res;

  // The held request moves through the parser when the result register is free
  // or is being emptied in this same cycle.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r  <= in_ch.in_byte;
      in_event_r <= in_ch.event_req;
    end
  end

  wcep_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .in_byte   (in_byte_r),
    .event_req (in_event_r),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.expr_kind  = out_res_r.expr_kind;
  assign out_ch.expr_value = out_res_r.expr_value;
  assign out_ch.status     = out_res_r.status;

  // A failed expression never reports an operand.
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |-> (out_res_r.expr_value == 64'd0))
    else $error("error result carries a nonzero value");

  // A held request that cannot advance keeps its contents.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_byte_r) && $stable(in_event_r)))
    else $error("stalled input register changed");

  // A waiting result is not overwritten by the parser.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !advance)
    else $error("parser advanced over a waiting result");

endmodule

[rtl/wcep_core.sv]
// Parser state and the per-byte next-state and result logic.
module wcep_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       in_byte,
  input  logic [1:0]       event_req,
  output logic             emit,
  output wcep_pkg::result_t res
);
  import wcep_pkg::*;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  bitpos_r, bitpos_nxt;
  logic [2:0]  rawcnt_r, rawcnt_nxt;

  logic [63:0] leb_part;
  logic [63:0] raw_part;
  logic [6:0]  bitpos_sum;

  assign leb_part   = bitpos_r[6] ? 64'd0
                      : ({56'd0, in_byte & LEB_PAYLOAD} << bitpos_r[5:0]);
  assign raw_part   = {56'd0, in_byte} << {rawcnt_r, 3'b000};
  assign bitpos_sum = bitpos_r + BITPOS_STEP;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    bitpos_nxt = bitpos_r;
    rawcnt_nxt = rawcnt_r;
    emit       = 1'b0;
    res        = '{expr_kind: kind_r, expr_value: 64'd0, status: ST_OK};

    unique case (phase_r)
      PH_OPCODE: begin
        if (event_req == EV_DATA) begin
          acc_nxt    = 64'd0;
          bitpos_nxt = 7'd0;
          rawcnt_nxt = 3'd0;
          unique case (in_byte)
            OP_I32_CONST: begin
              kind_nxt = KIND_I32; phase_nxt = PH_LEB;
            end
            OP_I64_CONST: begin
              kind_nxt = KIND_I64; phase_nxt = PH_LEB;
            end
            OP_F32_CONST: begin
              kind_nxt = KIND_F32; phase_nxt = PH_RAW;
            end
            OP_F64_CONST: begin
              kind_nxt = KIND_F64; phase_nxt = PH_RAW;
            end
            OP_GLOBAL_GET: begin
              kind_nxt = KIND_GLOBAL; phase_nxt = PH_LEB;
            end
            default: begin
              emit     = 1'b1;
              res      = '{expr_kind: KIND_I32, expr_value: 64'd0, status: ST_BAD};
              kind_nxt = KIND_I32;
            end
          endcase
        end
      end
      PH_LEB: begin
        if (event_req != EV_DATA) begin
          emit = 1'b1;
          res.status = (event_req == EV_EOS) ? ST_LEB_EOS : ST_LEB_ERR;
        end else begin
          acc_nxt = acc_r | leb_part;
          if (kind_r != KIND_I64) begin
            acc_nxt[63:32] = 32'd0;
          end
          if ((in_byte & LEB_MORE) == 8'd0) begin
            phase_nxt = PH_END;
          end else begin
            bitpos_nxt = (bitpos_sum > BITPOS_SAT) ? BITPOS_SAT : bitpos_sum;
          end
        end
      end
      PH_RAW: begin
        if (event_req != EV_DATA) begin
          emit = 1'b1;
          res.status = ST_BAD;
        end else begin
          acc_nxt = acc_r | raw_part;
          if (rawcnt_r == ((kind_r == KIND_F64) ? 3'd7 : 3'd3)) begin
            phase_nxt  = PH_END;
            rawcnt_nxt = 3'd0;
          end else begin
            rawcnt_nxt = rawcnt_r + 3'd1;
          end
        end
      end
      PH_END: begin
        emit = 1'b1;
        if (event_req != EV_DATA || in_byte != OP_END) begin
          res.status = ST_BAD;
        end else begin
          res.expr_value = acc_r;
        end
      end
      default: begin
        phase_nxt = PH_OPCODE;
      end
    endcase

    // Every result sends the parser back to waiting for an opcode.
    if (emit) begin
      phase_nxt  = PH_OPCODE;
      kind_nxt   = KIND_I32;
      acc_nxt    = 64'd0;
      bitpos_nxt = 7'd0;
      rawcnt_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      kind_r   <= KIND_I32;
      acc_r    <= 64'd0;
      bitpos_r <= 7'd0;
      rawcnt_r <= 3'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      acc_r    <= acc_nxt;
      bitpos_r <= bitpos_nxt;
      rawcnt_r <= rawcnt_nxt;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the WebAssembly constant expression parser.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wcep_pkg::*;

  // Read error events. The block treats the unused code 3 as a read error too.
  localparam logic [1:0] EV_RD_ERR     = 2'd2;
  localparam logic [1:0] EV_RD_ERR_ALT = 2'd3;

  localparam int unsigned RANDOM_DATA_BYTES = 850;
  // The result channel is held off once, after this many requests, for this many cycles.
  localparam int unsigned HOLD_AFTER_REQS   = 300;
  localparam int unsigned HOLD_CYCLES       = 400;

  // Tracks the parser state from the accepted requests, keeps the results that
  // must come out in order, and compares each delivered result against them.
  class expr_scoreboard;
    phase_t      ph       = PH_OPCODE;
    kind_t       op_kind  = KIND_I32;
    logic [63:0] acc      = '0;
    int unsigned bit_pos  = 0;
    int unsigned raw_idx  = 0;
    result_t     expected_exprs[$];
    int unsigned failures = 0;
    int unsigned requests = 0;
    int unsigned ok_count = 0;
    int unsigned err_count = 0;

    // Queues the result of the current expression and goes back to waiting
    // for an opcode.
    function void close_expr(kind_t k, logic [63:0] v, status_t s);
      result_t r;
      r.expr_kind  = k;
      r.expr_value = v;
      r.status     = s;
      expected_exprs.push_back(r);
      ph      = PH_OPCODE;
      op_kind = KIND_I32;
      acc     = '0;
      bit_pos = 0;
      raw_idx = 0;
    endfunction

    function void note_request(logic [7:0] b, logic [1:0] ev);
      int unsigned raw_len;
      requests++;
      case (ph)
        PH_OPCODE: begin
          // Stream events between expressions are dropped without a result.
          if (ev != EV_DATA) return;
          acc     = '0;
          bit_pos = 0;
          raw_idx = 0;
          case (b)
            OP_I32_CONST: begin
              op_kind = KIND_I32;
              ph      = PH_LEB;
            end
            OP_I64_CONST: begin
              op_kind = KIND_I64;
              ph      = PH_LEB;
            end
            OP_F32_CONST: begin
              op_kind = KIND_F32;
              ph      = PH_RAW;
            end
            OP_F64_CONST: begin
              op_kind = KIND_F64;
              ph      = PH_RAW;
            end
            OP_GLOBAL_GET: begin
              op_kind = KIND_GLOBAL;
              ph      = PH_LEB;
            end
            default: close_expr(KIND_I32, '0, ST_BAD);
          endcase
        end
        PH_LEB: begin
          if (ev == EV_EOS) begin
            close_expr(op_kind, '0, ST_LEB_EOS);
          end else if (ev != EV_DATA) begin
            close_expr(op_kind, '0, ST_LEB_ERR);
          end else begin
            if (bit_pos < 64) acc |= {56'd0, b & LEB_PAYLOAD} << bit_pos;
            // i32 and global indexes keep only 32 bits.
            if (op_kind != KIND_I64) acc[63:32] = '0;
            if ((b & LEB_MORE) == 8'd0) begin
              ph = PH_END;
            end else begin
              bit_pos += BITPOS_STEP;
              if (bit_pos > BITPOS_SAT) bit_pos = BITPOS_SAT;
            end
          end
        end
        PH_RAW: begin
          raw_len = (op_kind == KIND_F64) ? 8 : 4;
          if (ev != EV_DATA) begin
            close_expr(op_kind, '0, ST_BAD);
          end else begin
            acc |= {56'd0, b} << (raw_idx * 8);
            if (raw_idx + 1 >= raw_len) begin
              ph      = PH_END;
              raw_idx = 0;
            end else begin
              raw_idx++;
            end
          end
        end
        default: begin
          if (ev != EV_DATA || b != OP_END) close_expr(op_kind, '0, ST_BAD);
          else close_expr(op_kind, acc, ST_OK);
        end
      endcase
    endfunction

    function void check_result(logic [2:0] k, logic [63:0] v, logic [1:0] s);
      result_t want;
      if (expected_exprs.size() == 0) begin
        $error("result with nothing expected: expr_kind %0d expr_value %h status %0d",
               k, v, s);
        failures++;
        return;
      end
      want = expected_exprs.pop_front();
      if (want.status == ST_OK) ok_count++;
      else err_count++;
      if (k !== want.expr_kind) begin
        $error("expr_kind mismatch: expected %0d, actual %0d", want.expr_kind, k);
        failures++;
      end
      if (v !== want.expr_value) begin
        $error("expr_value mismatch: expected %h, actual %h", want.expr_value, v);
        failures++;
      end
      if (s !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, s);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  wcep_in_if  in_ch();
  wcep_out_if out_ch();

  wasm_const_expr_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  expr_scoreboard sb = new;

  // Sender burst state: requests left in the current burst.
  int unsigned burst_left = 0;
  int unsigned data_bytes = 0;
  // Set when a random expression was cut short by a stream event.
  logic        expr_cut   = 1'b0;

  // Receiver state: the stall pattern in use and how long it lasts, plus the
  // single long hold-off that backs the block up into its input.
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  // Results are checked on the values sampled at the edge where valid and
  // ready were both high. The ready for the next cycle is chosen at the same
  // edge: mostly one of a few stall patterns, once a long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.expr_kind, out_ch.expr_value, out_ch.status);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && sb.requests >= HOLD_AFTER_REQS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 150);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic [1:0] random_event();
    case ($urandom_range(0, 2))
      0: return EV_EOS;
      1: return EV_RD_ERR;
      default: return EV_RD_ERR_ALT;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is taken. The sender
  // runs in bursts; a gap of idle cycles may come before a new burst. A gap of
  // zero leaves valid high so it is never lowered and raised in one step.
  task automatic send_req(input logic [7:0] b, input logic [1:0] ev);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.event_req <= ev;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sb.note_request(b, ev);
    if (ev == EV_DATA) data_bytes++;
  endtask

  // An operand byte that now and then is replaced by a stream event, which
  // ends the expression early.
  task automatic send_operand_byte(input logic [7:0] b);
    if ($urandom_range(0, 49) == 0) begin
      send_req(b, random_event());
      expr_cut = 1'b1;
    end else begin
      send_req(b, EV_DATA);
    end
  endtask

  // One random expression. Most are well formed with random operands; the
  // rest carry unknown opcodes, overlong or oversized LEB operands, cut-off
  // operands, a wrong end byte, or stray events between expressions.
  task automatic send_expr();
    logic [7:0]  opc;
    logic [7:0]  b;
    logic [63:0] val;
    int unsigned nbits;
    int unsigned pad;
    int unsigned roll;
    expr_cut = 1'b0;
    if ($urandom_range(0, 24) == 0) send_req(8'($urandom), random_event());

    case ($urandom_range(0, 10))
      0, 1:    opc = OP_I32_CONST;
      2, 3, 4: opc = OP_I64_CONST;
      5, 6:    opc = OP_F32_CONST;
      7, 8:    opc = OP_F64_CONST;
      9:       opc = OP_GLOBAL_GET;
      default: opc = 8'($urandom);
    endcase
    send_req(opc, EV_DATA);

    if (opc == OP_I32_CONST || opc == OP_I64_CONST || opc == OP_GLOBAL_GET) begin
      // Operand size: a few always run to 64 bits, so i32 operands also get
      // payload past bit 31 that has to be dropped.
      if ($urandom_range(0, 9) < 3) nbits = 64;
      else nbits = $urandom_range(1, (opc == OP_I64_CONST) ? 64 : 40);
      roll = $urandom_range(0, 19);
      if (roll < 3) val = '1;
      else if (roll == 3) val = '0;
      else val = {$urandom, $urandom};
      if (nbits < 64) val &= (64'd1 << nbits) - 64'd1;
      // Overlong encodings add continuation bytes with random payload; the
      // longest ones drive the bit position into saturation.
      pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
      while (1) begin
        b   = {1'b0, val[6:0]};
        val = val >> 7;
        b   = b | ((val != 0 || pad != 0) ? LEB_MORE : 8'd0);
        send_operand_byte(b);
        if (expr_cut) return;
        if ((b & LEB_MORE) == 8'd0) break;
        if (val == 0) break;
      end
      while (pad != 0) begin
        pad--;
        b = (8'($urandom) & LEB_PAYLOAD) | ((pad != 0) ? LEB_MORE : 8'd0);
        send_operand_byte(b);
        if (expr_cut) return;
      end
    end else if (opc == OP_F32_CONST || opc == OP_F64_CONST) begin
      repeat ((opc == OP_F64_CONST) ? 8 : 4) begin
        send_operand_byte(8'($urandom));
        if (expr_cut) return;
      end
    end else begin
      // Unknown opcode: the block reports it at once.
      return;
    end

    roll = $urandom_range(0, 99);
    if (roll < 90) send_req(OP_END, EV_DATA);
    else if (roll < 95) send_req(8'($urandom), EV_DATA);
    else send_req(8'($urandom), random_event());
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'd0;
    in_ch.event_req <= EV_DATA;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Events outside an expression give no result.
    send_req(8'h5a, EV_EOS);
    send_req(8'ha5, EV_RD_ERR_ALT);
    // Unknown opcode.
    send_req(8'hff, EV_DATA);
    // One-byte i32 operand with all payload bits set.
    send_req(OP_I32_CONST, EV_DATA);
    send_req(LEB_PAYLOAD, EV_DATA);
    send_req(OP_END, EV_DATA);
    // Global index zero.
    send_req(OP_GLOBAL_GET, EV_DATA);
    send_req(8'h00, EV_DATA);
    send_req(OP_END, EV_DATA);
    // End of stream and read error inside a LEB operand.
    send_req(OP_I64_CONST, EV_DATA);
    send_req(8'h00, EV_EOS);
    send_req(OP_I32_CONST, EV_DATA);
    send_req(8'hff, EV_RD_ERR);
    // Short read of raw f32 bytes.
    send_req(OP_F32_CONST, EV_DATA);
    send_req(8'haa, EV_DATA);
    send_req(8'h00, EV_EOS);
    // f64 with every bit set.
    send_req(OP_F64_CONST, EV_DATA);
    repeat (8) send_req(8'hff, EV_DATA);
    send_req(OP_END, EV_DATA);
    // Wrong byte, then an event, where the end byte is expected.
    send_req(OP_I32_CONST, EV_DATA);
    send_req(8'h00, EV_DATA);
    send_req(8'h0c, EV_DATA);
    send_req(OP_GLOBAL_GET, EV_DATA);
    send_req(8'h05, EV_DATA);
    send_req(8'h00, EV_EOS);

    data_bytes = 0;
    while (data_bytes < RANDOM_DATA_BYTES) send_expr();
    in_ch.valid <= 1'b0;

    // Drain: wait for every expected result, then a few cycles more so a
    // stray extra result would still be caught.
    while (sb.expected_exprs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests; %0d results checked, %0d ok and %0d with an error status.",
             sb.requests, sb.ok_count + sb.err_count, sb.ok_count, sb.err_count);
    $display("The result channel was held off once for %0d cycles under load.", HOLD_CYCLES);
    if (sb.failures == 0 && sb.expected_exprs.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected.", sb.expected_exprs.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
